>>> sv/lesq_pkg.sv
`timescale 1ns / 1ps
// Package for the largest empty square scanner: field widths, register
// indexes and reset values of the configuration registers. No dependencies.
package lesq_pkg;

    localparam int CHAR_W = 8;
    localparam int SIDE_W = 11;
    localparam int ROW_W  = 16;
    localparam int BCOL_W = 10;
    localparam int NCOL_W = 11;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;

    localparam logic [SIDE_W-1:0] SIDE_SAT = '1;

    localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST = 8'd46;
    localparam logic [NCOL_W-1:0] NUM_COLS_RST   = 11'd1024;
    localparam logic [ROW_W-1:0]  NUM_ROWS_RST   = 16'd1;

    typedef enum logic [CIDX_W-1:0] {
        CFG_EMPTY_CHAR = 2'd0,
        CFG_NUM_COLS   = 2'd1,
        CFG_NUM_ROWS   = 2'd2
    } cfg_index_t;

endpackage

>>> sv/largest_empty_square_scan.sv
`timescale 1ns / 1ps
// Largest empty square scanner: top level with line buffer and output register.
// Depends on lesq_pkg.
//
// The block takes one map character per word in raster order and returns one
// word per cell: the side of the largest free square ending at that cell, and
// the best square so far with its bottom-right corner. It sustains one word per
// clock unless the output stalls; each cell passes the compute stage and the
// output register. The previous row's sides live in a line buffer of MAX_COLS
// entries that is read once and written once per cell: the read is issued when
// a cell is accepted, the side is computed and written back in the next stage,
// and a write to the column being read in the same cycle is forwarded. The line
// buffer needs no clearing; the first row of a map never uses it. The word
// with tlast set is the last cell of a map, after which the row and column
// counters and the best square start over. Configuration may only be written
// while no word is in flight.
module largest_empty_square_scan
    import lesq_pkg::*;
#(
    parameter int MAX_COLS = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration write port.
    input  logic                cfg_we,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    // Input cells.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] cell_char
    // Results.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [47:0]         m_axis_tdata,   // [10:0] square_side, [21:11] best_side,
                                                // [37:22] best_row, [47:38] best_col
    output logic                m_axis_tlast    // map_done
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int CMP_W = (COL_W + 1 > NCOL_W) ? COL_W + 1 : NCOL_W;
    localparam logic [CMP_W-1:0] COLS_MAX = CMP_W'(MAX_COLS);

    // Configuration registers.
    logic [CHAR_W-1:0] empty_char_reg;
    logic [NCOL_W-1:0] num_cols_reg;
    logic [ROW_W-1:0]  num_rows_reg;

    // Position counters of the next cell to be accepted.
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    // Compute stage.
    logic              s1_valid_reg;
    logic              s1_free_reg;
    logic              s1_done_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_fwd_reg;
    logic [SIDE_W-1:0] s1_fwd_val_reg;
    logic [SIDE_W-1:0] rd_data_reg;

    // Running state of the current map.
    logic [SIDE_W-1:0] left_reg, left_next;
    logic [SIDE_W-1:0] diag_reg, diag_next;
    logic [SIDE_W-1:0] best_side_reg, best_side_next;
    logic [ROW_W-1:0]  best_row_reg, best_row_next;
    logic [BCOL_W-1:0] best_col_reg, best_col_next;

    // Output register.
    logic              out_valid_reg;
    logic [SIDE_W-1:0] out_side_reg;
    logic [SIDE_W-1:0] out_best_side_reg;
    logic [ROW_W-1:0]  out_best_row_reg;
    logic [BCOL_W-1:0] out_best_col_reg;
    logic              out_done_reg;

    logic [SIDE_W-1:0] line_mem [MAX_COLS];

    logic              accept;
    logic              s1_adv;
    logic [CMP_W-1:0]  cols_eff;
    logic [ROW_W-1:0]  rows_eff;
    logic              last_col;
    logic              done;
    logic [SIDE_W-1:0] up;
    logic [SIDE_W-1:0] min_ul;
    logic [SIDE_W-1:0] min3;
    logic [SIDE_W:0]   inc;
    logic [SIDE_W-1:0] side;

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------
    // Configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_char_reg <= EMPTY_CHAR_RST;
            num_cols_reg   <= NUM_COLS_RST;
            num_rows_reg   <= NUM_ROWS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_EMPTY_CHAR: empty_char_reg <= cfg_data[CHAR_W-1:0];
                CFG_NUM_COLS:   num_cols_reg   <= cfg_data[NCOL_W-1:0];
                CFG_NUM_ROWS:   num_rows_reg   <= cfg_data[ROW_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Accept stage: end of row and end of map are known from the counters.
    always_comb
    begin
        cols_eff = CMP_W'(num_cols_reg);
        if (cols_eff == '0)
        begin
            cols_eff = CMP_W'(1);
        end
        else if (cols_eff > COLS_MAX)
        begin
            cols_eff = COLS_MAX;
        end
        rows_eff = (num_rows_reg == '0) ? ROW_W'(1) : num_rows_reg;

        last_col = (CMP_W'(col_reg) + CMP_W'(1)) >= cols_eff;
        done     = last_col && (row_reg >= rows_eff - ROW_W'(1));

        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            priority if (done)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (last_col)
            begin
                row_next = row_reg + ROW_W'(1);
                col_next = '0;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_free_reg     <= (s_axis_tdata == empty_char_reg);
            s1_done_reg     <= done;
            s1_row_reg      <= row_reg;
            s1_col_reg      <= col_reg;
            // The cell in the compute stage writes this column right now.
            s1_fwd_reg      <= s1_adv && (s1_col_reg == col_reg);
            s1_fwd_val_reg  <= side;
        end
    end

    // Line buffer: read on accept, written when the compute stage moves on.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= line_mem[col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            line_mem[s1_col_reg] <= side;
        end
    end

    // ---------------------------------------------------------------
    // Compute stage.
    always_comb
    begin
        up     = s1_fwd_reg ? s1_fwd_val_reg : rd_data_reg;
        min_ul = (up < left_reg) ? up : left_reg;
        min3   = (min_ul < diag_reg) ? min_ul : diag_reg;
        inc    = {1'b0, min3} + (SIDE_W+1)'(1);

        priority if (s1_row_reg == '0 || s1_col_reg == '0)
        begin
            side = SIDE_W'(s1_free_reg);
        end
        else if (s1_free_reg)
        begin
            side = inc[SIDE_W] ? SIDE_SAT : inc[SIDE_W-1:0];
        end
        else
        begin
            side = '0;
        end

        best_side_next = best_side_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        if (side > best_side_reg)
        begin
            best_side_next = side;
            best_row_next  = s1_row_reg;
            best_col_next  = BCOL_W'(s1_col_reg);
        end
        left_next = side;
        diag_next = up;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            diag_reg      <= '0;
            best_side_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
        end
        else if (s1_adv)
        begin
            if (s1_done_reg)
            begin
                left_reg      <= '0;
                diag_reg      <= '0;
                best_side_reg <= '0;
                best_row_reg  <= '0;
                best_col_reg  <= '0;
            end
            else
            begin
                left_reg      <= left_next;
                diag_reg      <= diag_next;
                best_side_reg <= best_side_next;
                best_row_reg  <= best_row_next;
                best_col_reg  <= best_col_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_side_reg      <= side;
            out_best_side_reg <= best_side_next;
            out_best_row_reg  <= best_row_next;
            out_best_col_reg  <= best_col_next;
            out_done_reg      <= s1_done_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_best_col_reg, out_best_row_reg, out_best_side_reg, out_side_reg};
    assign m_axis_tlast  = out_done_reg;

`ifndef ASSERT_OFF
    // The reported best side is never smaller than the cell's own side.
    a_best_covers_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_best_side_reg >= out_side_reg))
        else $error("best side smaller than the cell's own side");

    // The last cell of a map leaves a clean running state behind.
    a_map_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_done_reg) |=> (best_side_reg == '0 && left_reg == '0
                                     && diag_reg == '0))
        else $error("running state not cleared after end of map");

    // A stalled compute stage must hold off new cells.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> !s_axis_tready)
        else $error("input accepted while the compute stage is stalled");

    // A word in the compute stage reaches the output register in the next cycle
    // when the output side is free.
    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("compute stage did not advance into a free output register");
`endif

endmodule
